/* rtl/earm_pkg.sv */
package earm_pkg;

    localparam int ANGLE_BITS       = 16;
    localparam int FRAC_BITS        = 14;
    localparam int SINE_TABLE_DEPTH = 256;

    localparam int TICK_W  = 8;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 3;
    localparam int OUT_W   = 16;
    localparam int N_ENTRY = 9;

    // Angle lookup geometry.
    localparam int QSHIFT = ANGLE_BITS - 2;
    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);

    // Datapath widths: sine/cosine, multiplier operands, exact entry sums.
    localparam int TRIG_W = FRAC_BITS + 2;
    localparam int MA_W   = 2 * FRAC_BITS + 2;
    localparam int MB_W   = (FRAC_BITS + 2 > CFG_W) ? FRAC_BITS + 2 : CFG_W;
    localparam int PROD_W = MA_W + MB_W;
    localparam int W3     = 3 * FRAC_BITS + 4;

    // Sequencer lengths.
    localparam int N_ADV  = 3;
    localparam int N_LOOK = 6;
    localparam int N_MUL  = 14;
    localparam int STEP_W = 4;

    // Register indexes of the configuration port.
    localparam logic [CIDX_W-1:0] REG_INIT_X  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_INIT_Y  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_INIT_Z  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_DELTA_X = 3'd3;
    localparam logic [CIDX_W-1:0] REG_DELTA_Y = 3'd4;
    localparam logic [CIDX_W-1:0] REG_DELTA_Z = 3'd5;

    localparam logic [63:0] PIH_Q30 = 64'h6487ED51;

    typedef logic [SINE_TABLE_DEPTH:0][FRAC_BITS:0] t_rom;

    // Quarter-wave sine table, built from a Taylor series at elaboration.
    function automatic t_rom sine_rom_build();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = (PIH_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            v = ((sum << FRAC_BITS) + (64'(1) << 29)) >> 30;
            if (v > (64'(1) << FRAC_BITS)) begin
                v = 64'(1) << FRAC_BITS;
            end
            rom[k] = v[FRAC_BITS:0];
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = sine_rom_build();

    typedef struct packed {
        logic              capture;
        logic              mul_go;
        logic              mul_phase;
        logic              look;
        logic [STEP_W-1:0] step;
        logic              load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

/* rtl/earm_ctrl.sv */
module earm_ctrl
    import earm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ADV    = 7'b0000010,
        S_ADV_WB = 7'b0000100,
        S_LOOK   = 7'b0001000,
        S_MUL    = 7'b0010000,
        S_MUL_WB = 7'b0100000,
        S_LOAD   = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_ADV;
                    n_step  = '0;
                end
            end
            S_ADV: begin
                if (r_step == STEP_W'(N_ADV - 1)) begin
                    n_state = S_ADV_WB;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_ADV_WB: begin
                n_state = S_LOOK;
            end
            S_LOOK: begin
                if (r_step == STEP_W'(N_LOOK - 1)) begin
                    n_state = S_MUL;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_MUL: begin
                if (r_step == STEP_W'(N_MUL - 1)) begin
                    n_state = S_MUL_WB;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_MUL_WB: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd.capture   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul_go    = (r_state == S_ADV) || (r_state == S_MUL);
        o_cmd.mul_phase = (r_state == S_MUL);
        o_cmd.look      = (r_state == S_LOOK);
        o_cmd.step      = r_step;
        o_cmd.load      = (r_state == S_LOAD) && i_stat.out_free;
    end

endmodule

/* rtl/earm_dpath.sv */
module earm_dpath
    import earm_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    output t_stat                       o_stat,
    input  logic [TICK_W-1:0]           i_elapsed_ticks,
    input  logic                        i_cfg_we,
    input  logic [CIDX_W-1:0]           i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_data,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [N_ENTRY-1:0][OUT_W-1:0] o_m
);

    typedef enum logic [1:0] {A_TRIG, A_PP0, A_PP1} t_asel;
    typedef enum logic [2:0] {T_SX, T_CX, T_SY, T_CY, T_SZ, T_CZ} t_trig;
    typedef enum logic [2:0] {WB_PP0, WB_PP1, WB_SET, WB_SETN, WB_ADD, WB_SUB} t_wb;

    typedef struct packed {
        t_asel       a_sel;
        t_trig       a_trig;
        t_trig       b_trig;
        t_wb         wb;
        logic        scaled;
        logic [3:0]  ent;
    } t_mop;

    localparam logic [3:0] E00 = 4'd0;
    localparam logic [3:0] E01 = 4'd1;
    localparam logic [3:0] E02 = 4'd2;
    localparam logic [3:0] E10 = 4'd3;
    localparam logic [3:0] E11 = 4'd4;
    localparam logic [3:0] E12 = 4'd5;
    localparam logic [3:0] E20 = 4'd6;
    localparam logic [3:0] E21 = 4'd7;
    localparam logic [3:0] E22 = 4'd8;

    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << QSHIFT;

    // Product schedule. sy*sx and cy*sx are kept and reused for the
    // three-factor terms; the entry for row 1 column 2 needs no product.
    function automatic t_mop mop_decode(input logic [STEP_W-1:0] s);
        t_mop m;
        m = '{A_TRIG, T_SY, T_SX, WB_PP0, 1'b0, E00};
        case (s)
            4'd0:  m = '{A_TRIG, T_SY, T_SX, WB_PP0,  1'b0, E00};
            4'd1:  m = '{A_TRIG, T_CY, T_SX, WB_PP1,  1'b0, E00};
            4'd2:  m = '{A_TRIG, T_CY, T_CZ, WB_SET,  1'b1, E00};
            4'd3:  m = '{A_PP0,  T_SX, T_SZ, WB_SUB,  1'b0, E00};
            4'd4:  m = '{A_TRIG, T_CY, T_SZ, WB_SET,  1'b1, E01};
            4'd5:  m = '{A_PP0,  T_SX, T_CZ, WB_ADD,  1'b0, E01};
            4'd6:  m = '{A_TRIG, T_SY, T_CX, WB_SETN, 1'b1, E02};
            4'd7:  m = '{A_TRIG, T_CX, T_SZ, WB_SETN, 1'b1, E10};
            4'd8:  m = '{A_TRIG, T_CX, T_CZ, WB_SET,  1'b1, E11};
            4'd9:  m = '{A_TRIG, T_SY, T_CZ, WB_SET,  1'b1, E20};
            4'd10: m = '{A_PP1,  T_SX, T_SZ, WB_ADD,  1'b0, E20};
            4'd11: m = '{A_TRIG, T_SY, T_SZ, WB_SET,  1'b1, E21};
            4'd12: m = '{A_PP1,  T_SX, T_CZ, WB_SUB,  1'b0, E21};
            4'd13: m = '{A_TRIG, T_CY, T_CX, WB_SET,  1'b1, E22};
            default: m = '{A_TRIG, T_SY, T_SX, WB_PP0, 1'b0, E00};
        endcase
        return m;
    endfunction

    // Round half up from 2*FRAC_BITS extra fraction bits, then saturate to +/-1.
    function automatic logic [OUT_W-1:0] fx_finish(input logic signed [W3-1:0] w);
        logic signed [W3-1:0] s;
        logic signed [W3-1:0] r;
        logic signed [W3-1:0] one;
        one = W3'(1) <<< FRAC_BITS;
        s   = w + (W3'(1) <<< (2 * FRAC_BITS - 1));
        r   = s >>> (2 * FRAC_BITS);
        if (r > one) begin
            r = one;
        end
        if (r < -one) begin
            r = -one;
        end
        return r[OUT_W-1:0];
    endfunction

    logic [ANGLE_BITS-1:0]    r_ang_x, r_ang_y, r_ang_z;
    logic [CFG_W-1:0]         r_dlt_x, r_dlt_y, r_dlt_z;
    logic [TICK_W-1:0]        r_ticks;
    logic signed [TRIG_W-1:0] r_sx, r_cx, r_sy, r_cy, r_sz, r_cz;
    logic signed [MA_W-1:0]   r_pp0, r_pp1;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_wb_vld;
    logic                     r_wb_mul;
    logic [STEP_W-1:0]        r_wb_step;
    logic signed [W3-1:0]     r_acc [N_ENTRY];
    logic [OUT_W-1:0]         r_out [N_ENTRY];
    logic                     r_out_valid;

    function automatic logic signed [TRIG_W-1:0] trig_sel(
        input t_trig t,
        input logic signed [TRIG_W-1:0] sx, cx, sy, cy, sz, cz
    );
        logic signed [TRIG_W-1:0] v;
        case (t)
            T_SX:    v = sx;
            T_CX:    v = cx;
            T_SY:    v = sy;
            T_CY:    v = cy;
            T_SZ:    v = sz;
            T_CZ:    v = cz;
            default: v = sx;
        endcase
        return v;
    endfunction

    // ---------------- table lookup ----------------
    logic [ANGLE_BITS-1:0]      lk_base;
    logic [ANGLE_BITS-1:0]      lk_ang;
    logic [1:0]                 lk_quad;
    logic [QSHIFT+IDX_W-1:0]    lk_scaled;
    logic [IDX_W-1:0]           lk_idx;
    logic [IDX_W-1:0]           lk_rix;
    logic signed [TRIG_W-1:0]   lk_mag;
    logic signed [TRIG_W-1:0]   lk_val;

    always_comb begin
        case (i_cmd.step[2:1])
            2'd0:    lk_base = r_ang_x;
            2'd1:    lk_base = r_ang_y;
            default: lk_base = r_ang_z;
        endcase
        // Odd steps give the cosine: the angle is moved on a quarter turn.
        lk_ang    = i_cmd.step[0] ? lk_base + QUARTER : lk_base;
        lk_quad   = lk_ang[ANGLE_BITS-1:ANGLE_BITS-2];
        lk_scaled = (QSHIFT + IDX_W)'(lk_ang[QSHIFT-1:0])
                  * (QSHIFT + IDX_W)'(SINE_TABLE_DEPTH);
        lk_idx    = lk_scaled[QSHIFT+IDX_W-1:QSHIFT];
        lk_rix    = lk_quad[0] ? IDX_W'(SINE_TABLE_DEPTH) - lk_idx : lk_idx;
        lk_mag    = $signed({1'b0, SINE_ROM[lk_rix]});
        lk_val    = lk_quad[1] ? -lk_mag : lk_mag;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            case (i_cmd.step)
                4'd0: r_sx <= lk_val;
                4'd1: r_cx <= lk_val;
                4'd2: r_sy <= lk_val;
                4'd3: r_cy <= lk_val;
                4'd4: r_sz <= lk_val;
                4'd5: r_cz <= lk_val;
                default: ;
            endcase
        end
    end

    // ---------------- shared multiplier ----------------
    t_mop                     is_mop;
    logic signed [MA_W-1:0]   op_a;
    logic signed [MB_W-1:0]   op_b;
    logic [CFG_W-1:0]         adv_dlt;

    always_comb begin
        is_mop = mop_decode(i_cmd.step);
        case (i_cmd.step)
            4'd0:    adv_dlt = r_dlt_x;
            4'd1:    adv_dlt = r_dlt_y;
            default: adv_dlt = r_dlt_z;
        endcase
        if (!i_cmd.mul_phase) begin
            op_a = $signed(MA_W'(r_ticks));
            op_b = MB_W'($signed(adv_dlt));
        end else begin
            case (is_mop.a_sel)
                A_PP0:   op_a = r_pp0;
                A_PP1:   op_a = r_pp1;
                default: op_a = MA_W'(trig_sel(is_mop.a_trig,
                                    r_sx, r_cx, r_sy, r_cy, r_sz, r_cz));
            endcase
            op_b = MB_W'(trig_sel(is_mop.b_trig, r_sx, r_cx, r_sy, r_cy, r_sz, r_cz));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ticks <= i_elapsed_ticks;
        end
        r_prod    <= op_a * op_b;
        r_wb_mul  <= i_cmd.mul_phase;
        r_wb_step <= i_cmd.step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_vld <= 1'b0;
        end else begin
            r_wb_vld <= i_cmd.mul_go;
        end
    end

    // ---------------- write back ----------------
    t_mop                 wb_mop;
    logic signed [W3-1:0] wb_term;

    always_comb begin
        wb_mop = mop_decode(r_wb_step);
        if (wb_mop.scaled) begin
            wb_term = W3'($signed(r_prod[MA_W-1:0])) <<< FRAC_BITS;
        end else begin
            wb_term = $signed(r_prod[W3-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_wb_vld && r_wb_mul) begin
            case (wb_mop.wb)
                WB_PP0:  r_pp0 <= $signed(r_prod[MA_W-1:0]);
                WB_PP1:  r_pp1 <= $signed(r_prod[MA_W-1:0]);
                WB_SET:  r_acc[wb_mop.ent] <= wb_term;
                WB_SETN: r_acc[wb_mop.ent] <= -wb_term;
                WB_ADD:  r_acc[wb_mop.ent] <= r_acc[wb_mop.ent] + wb_term;
                WB_SUB:  r_acc[wb_mop.ent] <= r_acc[wb_mop.ent] - wb_term;
                default: ;
            endcase
        end
    end

    // Angles and deltas; a write to an initial-angle register loads the angle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_x <= '0;
            r_ang_y <= '0;
            r_ang_z <= '0;
            r_dlt_x <= '0;
            r_dlt_y <= '0;
            r_dlt_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_INIT_X:  r_ang_x <= ANGLE_BITS'(i_cfg_data);
                REG_INIT_Y:  r_ang_y <= ANGLE_BITS'(i_cfg_data);
                REG_INIT_Z:  r_ang_z <= ANGLE_BITS'(i_cfg_data);
                REG_DELTA_X: r_dlt_x <= i_cfg_data;
                REG_DELTA_Y: r_dlt_y <= i_cfg_data;
                REG_DELTA_Z: r_dlt_z <= i_cfg_data;
                default: ;
            endcase
        end else if (r_wb_vld && !r_wb_mul) begin
            case (r_wb_step)
                4'd0: r_ang_x <= r_ang_x + r_prod[ANGLE_BITS-1:0];
                4'd1: r_ang_y <= r_ang_y + r_prod[ANGLE_BITS-1:0];
                4'd2: r_ang_z <= r_ang_z + r_prod[ANGLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int e = 0; e < N_ENTRY; e++) begin
                if (e == int'(E12)) begin
                    r_out[e] <= fx_finish(W3'(r_sx) <<< (2 * FRAC_BITS));
                end else begin
                    r_out[e] <= fx_finish(r_acc[e]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;

    always_comb begin
        for (int e = 0; e < N_ENTRY; e++) begin
            o_m[e] = r_out[e];
        end
    end

endmodule

/* rtl/euler_angle_rotation_matrix_unit.sv */
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_elapsed_ticks
// result    out        o_out_valid / i_out_ready o_m00 .. o_m22
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// An item is worked on from its transfer until its result is loaded, and the
// input stays closed until then. The pace is set by the single shared
// multiplier (3 angle steps and 14 matrix products) and the single sine table
// port (6 lookups). Synchronous reset clears the angles, the deltas, the
// controller and the valid flags. A result waiting on the output holds the
// next result back, while the following item is still taken in.
module euler_angle_rotation_matrix_unit
    import earm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [TICK_W-1:0]        i_elapsed_ticks,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [OUT_W-1:0]  o_m00,
    output logic signed [OUT_W-1:0]  o_m01,
    output logic signed [OUT_W-1:0]  o_m02,
    output logic signed [OUT_W-1:0]  o_m10,
    output logic signed [OUT_W-1:0]  o_m11,
    output logic signed [OUT_W-1:0]  o_m12,
    output logic signed [OUT_W-1:0]  o_m20,
    output logic signed [OUT_W-1:0]  o_m21,
    output logic signed [OUT_W-1:0]  o_m22,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CIDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    t_cmd                          cmd;
    t_stat                         stat;
    logic [N_ENTRY-1:0][OUT_W-1:0] m_bus;

    assign o_cfg_ready = 1'b1;

    earm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    earm_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_elapsed_ticks (i_elapsed_ticks),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_m             (m_bus)
    );

    assign o_m00 = m_bus[0];
    assign o_m01 = m_bus[1];
    assign o_m02 = m_bus[2];
    assign o_m10 = m_bus[3];
    assign o_m11 = m_bus[4];
    assign o_m12 = m_bus[5];
    assign o_m20 = m_bus[6];
    assign o_m21 = m_bus[7];
    assign o_m22 = m_bus[8];

    // An accepted item keeps the input closed until its work is done.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input still open after a transfer");

    // The angle steps start right after the item is taken.
    a_adv_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> (cmd.mul_go && !cmd.mul_phase))
        else $error("angle update did not follow the input transfer");

    // The multiplier and the table lookup never run in the same cycle.
    a_phase_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.mul_go && cmd.look))
        else $error("multiply and lookup overlap");

    // Loading the output register presents a result in the next cycle.
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> o_out_valid)
        else $error("result not presented after load");

endmodule
